// ===== hdl/bsp_pkg.sv =====
// Shared types, constants and the word population count for the bitmap store.
`default_nettype none

package bsp_pkg;

    localparam int BITS_DEF      = 4096;
    localparam int WORD_BITS_DEF = 32;

    localparam int IDX_W   = 12;
    localparam int MODE_W  = 3;
    localparam int COUNT_W = 13;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    localparam logic [63:0] POP_M1 = 64'h5555_5555_5555_5555;
    localparam logic [63:0] POP_M2 = 64'h3333_3333_3333_3333;
    localparam logic [63:0] POP_M4 = 64'h0F0F_0F0F_0F0F_0F0F;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE    = 3'd0,
        MODE_TEST     = 3'd1,
        MODE_FLIP     = 3'd2,
        MODE_COUNT    = 3'd3,
        MODE_CLEAR    = 3'd4,
        MODE_FLIP_ALL = 3'd5
    } t_mode;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_WR,
        ST_CNT,
        ST_FLP,
        ST_CLR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               any_set;
        logic [COUNT_W-1:0] ones_count;
        logic               bit_value;
    } t_result;

    function automatic logic [6:0] popcnt(input logic [63:0] word);
        logic [63:0] x;
        x = word - ((word >> 1) & POP_M1);
        x = (x & POP_M2) + ((x >> 2) & POP_M2);
        x = (x + (x >> 4)) & POP_M4;
        x = x + (x >> 8);
        x = x + (x >> 16);
        x = x + (x >> 32);
        return x[6:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bitmap_store_with_popcount.sv =====
// Bit vector store with single-bit write, test and flip, population count, clear and flip all.
//
// Input stream s_axis carries one request per beat: a mode, a bit index and a write value.
// Output stream m_axis returns exactly one result beat per request, in order.
// The words sit in a single-port-write, single-port-read memory with a registered read;
// one sequencer drives that memory and one shared popcount/invert datapath.
// Steps from accept to result valid:
//   write, test, flip (index in range): divide, read, modify/write, result
//   index out of range:                 divide, then an all-zero result
//   unused mode:                        all-zero result
//   count ones and flip all:            one word per cycle, then the result
//   clear all:                          one word written per cycle, then the result
// A new request is taken only when the sequencer is idle, so one request is in work at a time;
// the next request is accepted once the sequencer has returned to idle.
// The result register lets the next request enter while a result still waits.
// If the receiver stalls with a result waiting, a finished request holds until it drains.
// After reset the store is swept to zero, all NWORDS words (128 at the defaults), with
// s_axis_tready low; no result beat comes from that sweep.
`default_nettype none

module bitmap_store_with_popcount #(
    parameter int BITS      = bsp_pkg::BITS_DEF,
    parameter int WORD_BITS = bsp_pkg::WORD_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // mode [2:0], bit_index [14:3], new_value [15]
    input  wire logic [bsp_pkg::IN_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // bit_value [0], ones_count [13:1], any_set [14], zero [15]
    output logic [bsp_pkg::OUT_W-1:0]     m_axis_tdata
);

    import bsp_pkg::*;

    localparam int NWORDS    = (BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PW        = $clog2(WORD_BITS);
    localparam int ACC_W     = $clog2(BITS + 1);
    localparam int TAIL_BITS = BITS % WORD_BITS;
    localparam longint RECIP = ((64'd1 << 24) + WORD_BITS - 1) / WORD_BITS;

    localparam logic [AW:0]          NW_CNT    = (AW + 1)'(NWORDS);
    localparam logic [AW:0]          NW_LAST   = (AW + 1)'(NWORDS - 1);
    localparam logic [AW-1:0]        LAST_ADDR = AW'(NWORDS - 1);
    localparam logic [WORD_BITS-1:0] LAST_MASK = (TAIL_BITS != 0) ?
        WORD_BITS'((64'd1 << TAIL_BITS) - 64'd1) : {WORD_BITS{1'b1}};

    logic [WORD_BITS-1:0] mem [NWORDS];
    logic [WORD_BITS-1:0] r_rd_data;

    t_state           r_state, n_state;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_val, n_val;
    logic [IDX_W-1:0] r_q, n_q;
    logic [PW-1:0]    r_pos, n_pos;
    logic [AW:0]      r_ptr, n_ptr;
    logic [AW-1:0]    r_wptr, n_wptr;
    logic             r_pend, n_pend;
    logic [ACC_W-1:0] r_acc, n_acc;
    t_result          r_res, n_res;
    logic             r_o_valid, n_o_valid;
    t_result          r_o_res, n_o_res;

    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [WORD_BITS-1:0] mem_wd;
    logic                 mem_re;
    logic [AW-1:0]        mem_ra;

    logic [39:0]          quot_prod;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] mod_word;
    logic [WORD_BITS-1:0] flip_mask;
    logic [MODE_W-1:0]    s_mode;

    assign s_mode        = s_axis_tdata[2:0];
    assign quot_prod     = 40'(r_idx) * 40'(RECIP);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {1'b0, r_o_res};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_ptr     <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
        r_mode  <= n_mode;
        r_idx   <= n_idx;
        r_val   <= n_val;
        r_q     <= n_q;
        r_pos   <= n_pos;
        r_wptr  <= n_wptr;
        r_acc   <= n_acc;
        r_res   <= n_res;
        r_o_res <= n_o_res;
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_idx     = r_idx;
        n_val     = r_val;
        n_q       = r_q;
        n_pos     = r_pos;
        n_ptr     = r_ptr;
        n_wptr    = r_wptr;
        n_pend    = r_pend;
        n_acc     = r_acc;
        n_res     = r_res;
        n_o_valid = r_o_valid;
        n_o_res   = r_o_res;

        s_axis_tready = 1'b0;
        mem_we    = 1'b0;
        mem_wa    = r_wptr;
        mem_wd    = '0;
        mem_re    = 1'b0;
        mem_ra    = r_ptr[AW-1:0];
        bit_mask  = WORD_BITS'(1) << r_pos;
        mod_word  = r_rd_data;
        flip_mask = (r_wptr == LAST_ADDR) ? LAST_MASK : {WORD_BITS{1'b1}};

        if (r_o_valid && m_axis_tready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_INIT, ST_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_ptr[AW-1:0];
                mem_wd = '0;
                n_ptr  = r_ptr + 1'b1;
                if (r_ptr == NW_LAST) begin
                    n_state = (r_state == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_mode = s_mode;
                    n_idx  = s_axis_tdata[14:3];
                    n_val  = s_axis_tdata[15];
                    n_res  = '0;
                    n_ptr  = '0;
                    n_pend = 1'b0;
                    n_acc  = '0;
                    case (s_mode)
                        MODE_WRITE, MODE_TEST, MODE_FLIP: n_state = ST_DIV;
                        MODE_COUNT:                       n_state = ST_CNT;
                        MODE_CLEAR:                       n_state = ST_CLR;
                        MODE_FLIP_ALL:                    n_state = ST_FLP;
                        default:                          n_state = ST_DONE;
                    endcase
                end
            end
            ST_DIV: begin
                n_q = quot_prod[24 +: IDX_W];
                if (32'(r_idx) < BITS) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RD: begin
                mem_re  = 1'b1;
                mem_ra  = AW'(r_q);
                n_pos   = PW'(r_idx - IDX_W'(r_q * IDX_W'(WORD_BITS)));
                n_state = ST_WR;
            end
            ST_WR: begin
                case (r_mode)
                    MODE_WRITE: mod_word = r_val ? (r_rd_data | bit_mask)
                                                 : (r_rd_data & ~bit_mask);
                    MODE_FLIP:  mod_word = r_rd_data ^ bit_mask;
                    default:    mod_word = r_rd_data;
                endcase
                mem_we          = (r_mode != MODE_TEST);
                mem_wa          = AW'(r_q);
                mem_wd          = mod_word;
                n_res.bit_value = mod_word[r_pos];
                n_state         = ST_DONE;
            end
            ST_CNT, ST_FLP: begin
                if (r_ptr < NW_CNT) begin
                    mem_re = 1'b1;
                    mem_ra = r_ptr[AW-1:0];
                    n_ptr  = r_ptr + 1'b1;
                    n_pend = 1'b1;
                    n_wptr = r_ptr[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_state == ST_CNT) begin
                        n_acc = r_acc + ACC_W'(popcnt(64'(r_rd_data)));
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = r_wptr;
                        mem_wd = ~r_rd_data & flip_mask;
                    end
                end
                if (!(r_ptr < NW_CNT) && !r_pend) begin
                    if (r_state == ST_CNT) begin
                        n_res.any_set    = (r_acc != '0);
                        n_res.ones_count = (32'(r_acc) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                                       : COUNT_W'(r_acc);
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_o_valid || m_axis_tready) begin
                    n_o_valid = 1'b1;
                    n_o_res   = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/bsp_chk.sv =====
// Port-level checker for the bitmap store, bound to the top level.
`default_nettype none

module bsp_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [15:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a request is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15] == 1'b0))
        else $error("result padding bit set");

    a_count_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[13:1] != 13'd0)) |-> m_axis_tdata[14])
        else $error("nonzero count without any_set");

    a_bit_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && (m_axis_tdata[14:1] != 14'd0)))
        else $error("bit result and count result mixed");

endmodule

bind bitmap_store_with_popcount bsp_chk u_bsp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb_bitmap_store_with_popcount.sv =====
// Self-checking testbench for bitmap_store_with_popcount, with a built-in bitmap predictor.
module tb_bitmap_store_with_popcount;
    timeunit 1ns;
    timeprecision 1ps;

    import bsp_pkg::*;

    localparam int NWORDS        = BITS_DEF / WORD_BITS_DEF;
    localparam int RANDOM_ITEMS  = 925;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 300;
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // mode [2:0], bit_index [14:3], new_value [15]
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // bit_value [0], ones_count [13:1], any_set [14], zero [15]
    logic [OUT_W-1:0]  m_axis_tdata;

    logic [WORD_BITS_DEF-1:0] bitmap_words [NWORDS];
    logic [IN_W-1:0]          pending_beats [$];
    t_result                  expected_results [$];

    int beats_sent   = 0;
    int results_seen = 0;
    int error_count  = 0;
    int send_gap     = 0;
    int ready_gap    = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int stall_cycles = 0;

    bitmap_store_with_popcount u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        for (int w = 0; w < NWORDS; w++) bitmap_words[w] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic logic [IN_W-1:0] pack_request(input logic [MODE_W-1:0] mode,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic val);
        return {val, idx, mode};
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_result apply_to_bitmap(input logic [IN_W-1:0] beat);
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  idx;
        logic              val;
        int                wi;
        int                pos;
        int                total;
        t_result           res;
        mode = beat[2:0];
        idx  = beat[14:3];
        val  = beat[15];
        res  = '0;
        case (mode)
            MODE_WRITE, MODE_TEST, MODE_FLIP: begin
                if (int'(idx) < BITS_DEF) begin
                    wi  = int'(idx) / WORD_BITS_DEF;
                    pos = int'(idx) % WORD_BITS_DEF;
                    if (mode == MODE_WRITE) bitmap_words[wi][pos] = val;
                    else if (mode == MODE_FLIP) bitmap_words[wi][pos] = ~bitmap_words[wi][pos];
                    res.bit_value = bitmap_words[wi][pos];
                end
            end
            MODE_COUNT: begin
                total = 0;
                for (int w = 0; w < NWORDS; w++) total += $countones(bitmap_words[w]);
                res.any_set    = (total != 0);
                res.ones_count = (total > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(total);
            end
            MODE_CLEAR: begin
                for (int w = 0; w < NWORDS; w++) bitmap_words[w] = '0;
            end
            MODE_FLIP_ALL: begin
                for (int w = 0; w < NWORDS; w++) bitmap_words[w] = ~bitmap_words[w];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                expected_results.push_back(apply_to_bitmap(s_axis_tdata));
                beats_sent <= beats_sent + 1;
            end
            if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end else if (pending_beats.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_beats.pop_front();
                send_gap      <= pick_gap(beats_sent >= 400 && beats_sent < 500);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_gap     <= 0;
            hold_left     <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end else if (ready_gap != 0) begin
            m_axis_tready <= 1'b0;
            ready_gap     <= ready_gap - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (m_axis_tvalid && m_axis_tready)
                ready_gap <= pick_gap(results_seen >= 600 && results_seen < 700);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got          = t_result'(m_axis_tdata[14:0]);
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                $error("result beat with no request outstanding: %h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.bit_value !== want.bit_value) begin
                    $error("bit_value: expected %0d, got %0d", want.bit_value, got.bit_value);
                    error_count++;
                end
                if (got.ones_count !== want.ones_count) begin
                    $error("ones_count: expected %0d, got %0d", want.ones_count, got.ones_count);
                    error_count++;
                end
                if (got.any_set !== want.any_set) begin
                    $error("any_set: expected %0d, got %0d", want.any_set, got.any_set);
                    error_count++;
                end
                if (m_axis_tdata[15] !== 1'b0) begin
                    $error("pad: expected 0, got %0d", m_axis_tdata[15]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_bitmap_store_with_popcount: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int               hot_base;
        int               r;
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0] idx;
        hot_base = 0;
        pending_beats.push_back(pack_request(MODE_COUNT, 12'd0, 1'b0));
        pending_beats.push_back(pack_request(MODE_TEST, 12'd0, 1'b0));
        pending_beats.push_back(pack_request(MODE_TEST, 12'd4095, 1'b1));
        pending_beats.push_back(pack_request(MODE_WRITE, 12'd0, 1'b1));
        pending_beats.push_back(pack_request(MODE_WRITE, 12'd4095, 1'b1));
        pending_beats.push_back(pack_request(MODE_WRITE, 12'd31, 1'b1));
        pending_beats.push_back(pack_request(MODE_WRITE, 12'd32, 1'b1));
        pending_beats.push_back(pack_request(MODE_WRITE, 12'd31, 1'b1));
        pending_beats.push_back(pack_request(MODE_TEST, 12'd4095, 1'b0));
        pending_beats.push_back(pack_request(MODE_COUNT, 12'd4095, 1'b1));
        pending_beats.push_back(pack_request(MODE_FLIP, 12'd4095, 1'b1));
        pending_beats.push_back(pack_request(MODE_FLIP, 12'd100, 1'b0));
        pending_beats.push_back(pack_request(MODE_WRITE, 12'd0, 1'b0));
        pending_beats.push_back(pack_request(MODE_SPARE_A, 12'd4095, 1'b1));
        pending_beats.push_back(pack_request(MODE_SPARE_B, 12'd2730, 1'b1));
        pending_beats.push_back(pack_request(MODE_FLIP_ALL, 12'd0, 1'b0));
        pending_beats.push_back(pack_request(MODE_COUNT, 12'd0, 1'b0));
        pending_beats.push_back(pack_request(MODE_TEST, 12'd0, 1'b0));
        pending_beats.push_back(pack_request(MODE_CLEAR, 12'd4095, 1'b1));
        pending_beats.push_back(pack_request(MODE_COUNT, 12'd0, 1'b0));
        pending_beats.push_back(pack_request(MODE_FLIP_ALL, 12'd4095, 1'b1));
        pending_beats.push_back(pack_request(MODE_COUNT, 12'd0, 1'b0));
        pending_beats.push_back(pack_request(MODE_FLIP, 12'd2048, 1'b0));
        pending_beats.push_back(pack_request(MODE_CLEAR, 12'd0, 1'b0));
        pending_beats.push_back(pack_request(MODE_COUNT, 12'd0, 1'b0));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) hot_base = $urandom_range(0, BITS_DEF - 64);
            r = $urandom_range(0, 99);
            if (r < 35) mode = MODE_WRITE;
            else if (r < 55) mode = MODE_TEST;
            else if (r < 78) mode = MODE_FLIP;
            else if (r < 87) mode = MODE_COUNT;
            else if (r < 90) mode = MODE_CLEAR;
            else if (r < 96) mode = MODE_FLIP_ALL;
            else if (r < 98) mode = MODE_SPARE_A;
            else mode = MODE_SPARE_B;
            if ($urandom_range(0, 1) == 0) idx = IDX_W'($urandom_range(0, BITS_DEF - 1));
            else idx = IDX_W'(hot_base + $urandom_range(0, 63));
            pending_beats.push_back(pack_request(mode, idx, 1'($urandom_range(0, 1))));
        end
        @(negedge i_clk);
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (NWORDS + 16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_bitmap_store_with_popcount: done, clean");
        end else begin
            $display("tb_bitmap_store_with_popcount: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bsp_pkg.sv
hdl/bitmap_store_with_popcount.sv
hdl/bsp_chk.sv
tb/tb_bitmap_store_with_popcount.sv
